>>> sv/gttp_pkg.sv
// shared types, constants and helpers of the generation tagged timer pool
package gttp_pkg;

    localparam int TIMER_SLOTS_DEF = 16;

    localparam int NOW_W  = 48;
    localparam int IVL_W  = 31;
    localparam int DUE_W  = 49;
    localparam int GEN_W  = 8;
    localparam int SLOT_W = 8;
    localparam int TID_W  = 16;
    localparam int MODE_W = 2;
    localparam int KIND_W = 2;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 24;

    // request modes on the input stream
    localparam logic [MODE_W-1:0] MODE_TICK       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CREATE     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CANCEL     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CANCEL_ALL = 2'd3;

    // result kinds on the output stream
    localparam logic [KIND_W-1:0] KIND_CREATED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FAILED  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_CREATE,
        OP_CANCEL,
        OP_CANCEL_ALL
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [NOW_W-1:0] now;
        logic [IVL_W-1:0] ivl;
        logic             per;
        logic [TID_W-1:0] tid;
    } t_cmd;

    typedef struct packed {
        logic [GEN_W-1:0] gen;
        logic             per;
        logic [IVL_W-1:0] ivl;
        logic [DUE_W-1:0] due;
    } t_entry;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TID_W-1:0]  tid;
        logic              per;
        logic              last;
    } t_result;

    typedef enum logic [3:0] {
        B_IDLE,
        B_TICK_CHK,
        B_TICK_EVAL,
        B_TICK_REM,
        B_TICK_WR,
        B_TICK_END,
        B_CRT_SCAN,
        B_CRT_WR,
        B_CRT_FAIL,
        B_CAN_RD,
        B_CAN_EVAL,
        B_CALL_CHK,
        B_CALL_WR
    } t_bstate;

    // next generation, wrapping past zero
    function automatic logic [GEN_W-1:0] next_gen(input logic [GEN_W-1:0] g);
        logic [GEN_W-1:0] n;
        n = g + GEN_W'(1);
        if (n == '0) begin
            n = GEN_W'(1);
        end
        return n;
    endfunction

endpackage

>>> sv/gttp_ram.sv
// generic single write port ram with registered read
module gttp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/gttp_rem.sv
// bit serial remainder unit, returns divisor minus remainder
module gttp_rem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [gttp_pkg::NOW_W-1:0] i_dividend,
    input  logic [gttp_pkg::IVL_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [gttp_pkg::IVL_W-1:0] o_gap
);
    import gttp_pkg::*;

    localparam int CNT_W = $clog2(NOW_W + 1);

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NOW_W-1:0] r_dvd;
    logic [IVL_W-1:0] r_dvs;
    logic [IVL_W-1:0] r_rem;
    logic [IVL_W-1:0] r_gap;

    logic [IVL_W:0]   w_trial;
    logic [IVL_W-1:0] n_rem;

    // one restoring step per cycle, dividend msb first
    always_comb begin
        w_trial = {r_rem, r_dvd[NOW_W-1]};
        if (w_trial >= {1'b0, r_dvs}) begin
            n_rem = IVL_W'(w_trial - {1'b0, r_dvs});
        end else begin
            n_rem = IVL_W'(w_trial);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(NOW_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= {r_dvd[NOW_W-2:0], 1'b0};
            r_rem <= n_rem;
            if (r_cnt == CNT_W'(1)) begin
                r_gap <= r_dvs - n_rem;
            end
        end
    end

    assign o_done = r_done;
    assign o_gap  = r_gap;

endmodule

>>> sv/gttp_front.sv
// front part: request intake, classification and command queue
module gttp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [gttp_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic [gttp_pkg::MODE_W-1:0]    i_s_tuser,
    output gttp_pkg::t_cmd                o_cmd,
    output logic                          o_cmd_valid,
    input  logic                          i_cmd_pop
);
    import gttp_pkg::*;

    t_cmd       w_cmd;
    logic       w_push;
    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    // decode mode and unpack fields
    always_comb begin
        w_cmd.now = i_s_tdata[47:0];
        w_cmd.ivl = i_s_tdata[78:48];
        w_cmd.per = i_s_tdata[79];
        w_cmd.tid = i_s_tdata[95:80];
        case (i_s_tuser)
            MODE_TICK:       w_cmd.op = OP_TICK;
            MODE_CREATE:     w_cmd.op = OP_CREATE;
            MODE_CANCEL:     w_cmd.op = OP_CANCEL;
            MODE_CANCEL_ALL: w_cmd.op = OP_CANCEL_ALL;
            default:         w_cmd.op = OP_TICK;
        endcase
    end

    assign o_s_tready  = (r_count != 2'd2);
    assign w_push      = i_s_tvalid && o_s_tready;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, i_cmd_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

>>> sv/gttp_back.sv
// back part: slot sequencer over the slot ram, remainder unit and result register
module gttp_back #(
    parameter int TIMER_SLOTS = gttp_pkg::TIMER_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gttp_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_valid,
    output logic              o_cmd_pop,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output gttp_pkg::t_result o_res
);
    import gttp_pkg::*;

    localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int IW = $clog2(TIMER_SLOTS + 1);

    t_bstate                r_state, n_state;
    logic [IW-1:0]          r_idx, n_idx;
    logic [TIMER_SLOTS-1:0] r_busy, n_busy;
    logic [TIMER_SLOTS-1:0] r_gen_ok, n_gen_ok;
    logic                   r_pend_valid, n_pend_valid;
    logic [TID_W-1:0]       r_pend_tid, n_pend_tid;
    logic                   r_pend_per, n_pend_per;
    logic                   r_out_valid;
    t_result                r_out;
    t_cmd                   r_cmd;

    logic                   w_pop;
    logic                   w_emit;
    t_result                w_res;
    logic                   w_out_free;
    logic [AW-1:0]          w_slot;
    logic                   w_ram_we;
    t_entry                 w_wdata;
    t_entry                 w_rdata;
    logic                   w_rem_start;
    logic                   w_rem_done;
    logic [IVL_W-1:0]       w_rem_gap;
    logic [GEN_W-1:0]       w_gen_new;
    logic [SLOT_W-1:0]      w_can_slot;
    logic                   w_due_hit;

    assign w_slot     = r_idx[AW-1:0];
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_can_slot = i_cmd.tid[SLOT_W-1:0];
    assign w_due_hit  = ({1'b0, r_cmd.now} >= w_rdata.due);

    // slot entries: generation, periodic flag, interval, due time
    gttp_ram #(
        .WIDTH  ($bits(t_entry)),
        .DEPTH  (TIMER_SLOTS),
        .ADDR_W (AW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_slot),
        .i_wdata (w_wdata),
        .i_raddr (w_slot),
        .o_rdata (w_rdata)
    );

    // catch-up of periodic due times
    gttp_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (r_cmd.now - w_rdata.due[NOW_W-1:0]),
        .i_divisor  (w_rdata.ivl),
        .o_done     (w_rem_done),
        .o_gap      (w_rem_gap)
    );

    // sequencer next state and actions
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_busy       = r_busy;
        n_gen_ok     = r_gen_ok;
        n_pend_valid = r_pend_valid;
        n_pend_tid   = r_pend_tid;
        n_pend_per   = r_pend_per;
        w_pop        = 1'b0;
        w_emit       = 1'b0;
        w_res        = '0;
        w_ram_we     = 1'b0;
        w_wdata      = w_rdata;
        w_rem_start  = 1'b0;
        w_gen_new    = next_gen(r_gen_ok[w_slot] ? w_rdata.gen : GEN_W'(0));

        case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    w_pop = 1'b1;
                    n_idx = '0;
                    case (i_cmd.op)
                        OP_TICK:   n_state = B_TICK_CHK;
                        OP_CREATE: begin
                            n_state = (i_cmd.ivl == '0) ? B_CRT_FAIL : B_CRT_SCAN;
                        end
                        OP_CANCEL: begin
                            if (i_cmd.tid != '0 && w_can_slot < SLOT_W'(TIMER_SLOTS)) begin
                                n_idx   = IW'(w_can_slot);
                                n_state = B_CAN_RD;
                            end
                        end
                        OP_CANCEL_ALL: n_state = B_CALL_CHK;
                        default:       n_state = B_IDLE;
                    endcase
                end
            end

            // tick: walk the slots in order
            B_TICK_CHK: begin
                if (r_idx == IW'(TIMER_SLOTS)) begin
                    n_state = B_TICK_END;
                end else if (r_busy[w_slot]) begin
                    n_state = B_TICK_EVAL;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            B_TICK_EVAL: begin
                if (!w_due_hit) begin
                    n_idx   = r_idx + IW'(1);
                    n_state = B_TICK_CHK;
                end else if (!r_pend_valid || w_out_free) begin
                    // flush the previous expiry, hold this one back
                    if (r_pend_valid) begin
                        w_emit = 1'b1;
                        w_res  = '{kind: KIND_EXPIRED, tid: r_pend_tid,
                                   per: r_pend_per, last: 1'b0};
                    end
                    n_pend_valid = 1'b1;
                    n_pend_tid   = {w_rdata.gen, SLOT_W'(w_slot)};
                    n_pend_per   = w_rdata.per;
                    if (w_rdata.per) begin
                        w_rem_start = 1'b1;
                        n_state     = B_TICK_REM;
                    end else begin
                        n_busy[w_slot] = 1'b0;
                        n_idx          = r_idx + IW'(1);
                        n_state        = B_TICK_CHK;
                    end
                end
            end

            B_TICK_REM: begin
                if (w_rem_done) begin
                    n_state = B_TICK_WR;
                end
            end

            // due = now - ((now - due) mod interval) + interval
            B_TICK_WR: begin
                w_ram_we    = 1'b1;
                w_wdata.due = {1'b0, r_cmd.now} + DUE_W'(w_rem_gap);
                n_idx       = r_idx + IW'(1);
                n_state     = B_TICK_CHK;
            end

            B_TICK_END: begin
                if (!r_pend_valid) begin
                    n_state = B_IDLE;
                end else if (w_out_free) begin
                    w_emit       = 1'b1;
                    w_res        = '{kind: KIND_EXPIRED, tid: r_pend_tid,
                                     per: r_pend_per, last: 1'b1};
                    n_pend_valid = 1'b0;
                    n_state      = B_IDLE;
                end
            end

            // create: lowest free slot
            B_CRT_SCAN: begin
                if (r_idx == IW'(TIMER_SLOTS)) begin
                    n_state = B_CRT_FAIL;
                end else if (!r_busy[w_slot]) begin
                    n_state = B_CRT_WR;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            B_CRT_WR: begin
                if (w_out_free) begin
                    w_ram_we         = 1'b1;
                    w_wdata.gen      = w_gen_new;
                    w_wdata.per      = r_cmd.per;
                    w_wdata.ivl      = r_cmd.ivl;
                    w_wdata.due      = {1'b0, r_cmd.now} + DUE_W'(r_cmd.ivl);
                    n_busy[w_slot]   = 1'b1;
                    n_gen_ok[w_slot] = 1'b1;
                    w_emit           = 1'b1;
                    w_res            = '{kind: KIND_CREATED,
                                         tid: {w_gen_new, SLOT_W'(w_slot)},
                                         per: r_cmd.per, last: 1'b1};
                    n_state          = B_IDLE;
                end
            end

            B_CRT_FAIL: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    w_res   = '{kind: KIND_FAILED, tid: '0, per: 1'b0, last: 1'b1};
                    n_state = B_IDLE;
                end
            end

            // cancel: free on matching generation
            B_CAN_RD: begin
                n_state = B_CAN_EVAL;
            end

            B_CAN_EVAL: begin
                if (r_busy[w_slot] && w_rdata.gen == r_cmd.tid[TID_W-1:SLOT_W]) begin
                    n_busy[w_slot] = 1'b0;
                end
                n_state = B_IDLE;
            end

            // cancel all: free busy slots and advance their generation
            B_CALL_CHK: begin
                if (r_idx == IW'(TIMER_SLOTS)) begin
                    n_state = B_IDLE;
                end else if (r_busy[w_slot]) begin
                    n_state = B_CALL_WR;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            B_CALL_WR: begin
                w_ram_we       = 1'b1;
                w_wdata.gen    = next_gen(w_rdata.gen);
                n_busy[w_slot] = 1'b0;
                n_idx          = r_idx + IW'(1);
                n_state        = B_CALL_CHK;
            end

            default: n_state = B_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_idx        <= '0;
            r_busy       <= '0;
            r_gen_ok     <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_busy       <= n_busy;
            r_gen_ok     <= n_gen_ok;
            r_pend_valid <= n_pend_valid;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend_tid <= n_pend_tid;
        r_pend_per <= n_pend_per;
        if (w_pop) begin
            r_cmd <= i_cmd;
        end
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_cmd_pop  = w_pop;
    assign o_m_tvalid = r_out_valid;
    assign o_res      = r_out;

endmodule

>>> sv/generation_tagged_timer_pool_unit.sv
// Top level of the generation tagged timer pool.
// Tick: visits every slot in order and evaluates each busy one; a periodic expiry
//   also runs the 48-step bit serial remainder unit for the due time catch-up.
// Create: scans for the lowest free slot, one slot tested per cycle; cancel reads
//   only its own slot; cancel all visits every slot. A 2-entry queue takes
//   requests while the slot sequencer works. Synchronous reset frees all slots
//   and zeroes generations at once, no clearing pass.
module generation_tagged_timer_pool_unit #(
    parameter int TIMER_SLOTS = gttp_pkg::TIMER_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // now_ms[47:0], delay_ms[78:48], periodic[79], timer_id[95:80]
    input  logic [gttp_pkg::S_TDATA_W-1:0] i_s_tdata,
    // mode[1:0]
    input  logic [gttp_pkg::MODE_W-1:0]    i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // timer_id_res[15:0], periodic_res[16], zero fill [23:17]
    output logic [gttp_pkg::M_TDATA_W-1:0] o_m_tdata,
    // kind[1:0]
    output logic [gttp_pkg::KIND_W-1:0]    o_m_tuser,
    output logic                          o_m_tlast
);
    import gttp_pkg::*;

    t_cmd    w_cmd;
    logic    w_cmd_valid;
    logic    w_cmd_pop;
    t_result w_res;

    // request intake and queue
    gttp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    // slot sequencer
    gttp_back #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_res       (w_res)
    );

    // result packing
    assign o_m_tdata = {(M_TDATA_W - TID_W - 1)'(0), w_res.per, w_res.tid};
    assign o_m_tuser = w_res.kind;
    assign o_m_tlast = w_res.last;

endmodule
